// ===== sv/tscc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tscc_pkg;

  localparam int NUM_STATIONS  = 16;
  localparam int OUTER_WINDOWS = 8;
  localparam int QUEUE_DEPTH   = 2;

  localparam int WIN_BASE   = 1920;
  localparam int WIN_STEP   = 640;
  localparam int WIN_HALF   = 160;
  localparam int REPORT_MAX = 31;

  localparam int STN_W   = $clog2(NUM_STATIONS);
  localparam int RUN_W   = $clog2(NUM_STATIONS + 1);
  localparam int WIN_W   = (OUTER_WINDOWS > 1) ? $clog2(OUTER_WINDOWS) : 1;
  localparam int IDX_W   = 9;
  localparam int CNT_W   = 4;
  localparam int MOM_W   = 24;
  localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    FN_INNER_POINT = 3'd0,
    FN_OUTER_POINT = 3'd1,
    FN_INNER_HIT   = 3'd2,
    FN_OUTER_HIT   = 3'd3,
    FN_END         = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    CFG_INNER_STATIONS = 3'd0,
    CFG_MIN_STATIONS   = 3'd1,
    CFG_COVERAGE_MODE  = 3'd2,
    CFG_MIN_MOMENTUM   = 3'd3,
    CFG_MAX_POINTS     = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    COV_NONE      = 2'd0,
    COV_HIT_RUN   = 2'd1,
    COV_HIT_TOTAL = 2'd2,
    COV_POINT_RUN = 2'd3
  } cov_mode_t;

  typedef enum logic [1:0] {
    CMD_POINT = 2'd0,
    CMD_HIT   = 2'd1,
    CMD_END   = 2'd2
  } cmd_op_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_SCAN = 1'b1
  } back_state_t;

  typedef struct packed {
    logic [3:0]       inner_station_count;
    logic [4:0]       min_station_count;
    cov_mode_t        coverage_mode;
    logic [MOM_W-1:0] min_momentum;
    logic [3:0]       max_points_per_station;
  } cfg_t;

  typedef struct packed {
    cmd_op_t          op;
    logic [STN_W-1:0] idx;
    logic [MOM_W-1:0] mom;
  } cmd_t;

  typedef struct packed {
    logic             reconstructable;
    logic [4:0]       longest_point_run;
    logic [4:0]       longest_hit_run;
    logic [4:0]       hit_station_total;
    logic [CNT_W-1:0] most_points_on_station;
  } res_t;

  function automatic logic [4:0] sat_report(input logic [RUN_W-1:0] v);
    logic [4:0] r;
    if (32'(v) > REPORT_MAX) begin
      r = 5'(REPORT_MAX);
    end else begin
      r = 5'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/tscc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tscc_front import tscc_pkg::*; (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         func,
  input  logic [7:0]         station_number,
  input  logic signed [15:0] z_position,
  input  logic [MOM_W-1:0]   track_momentum,
  input  logic [3:0]         inner_station_count,
  input  logic               q_ready,
  output logic               push,
  output cmd_t               cmd
);

  logic             win_found;
  logic [WIN_W-1:0] win_idx;
  logic [IDX_W-1:0] st_idx;
  logic [IDX_W-1:0] raw_idx;
  logic             keep;

  always_comb begin
    logic signed [17:0] d;
    win_found = 1'b0;
    win_idx   = '0;
    for (int w = 0; w < OUTER_WINDOWS; w++) begin
      d = {{2{z_position[15]}}, z_position} - 18'(WIN_BASE + WIN_STEP * w);
      if (d < 18'(WIN_HALF) && d > -18'(WIN_HALF)) begin
        win_found = 1'b1;
        win_idx   = WIN_W'(w);
      end
    end
  end

  assign st_idx = {1'b0, station_number} - 9'd1;

  always_comb begin
    keep    = 1'b0;
    raw_idx = '0;
    cmd.op  = CMD_POINT;
    cmd.mom = track_momentum;
    unique case (func)
      FN_INNER_POINT: begin
        raw_idx = st_idx;
        keep    = station_number != 8'd0;
      end
      FN_OUTER_POINT: begin
        raw_idx = IDX_W'(win_idx) + IDX_W'(inner_station_count);
        keep    = win_found;
      end
      FN_INNER_HIT: begin
        cmd.op  = CMD_HIT;
        raw_idx = st_idx;
        keep    = station_number != 8'd0;
      end
      FN_OUTER_HIT: begin
        cmd.op  = CMD_HIT;
        raw_idx = st_idx + IDX_W'(inner_station_count);
        keep    = station_number != 8'd0;
      end
      FN_END: begin
        cmd.op = CMD_END;
        keep   = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
    if (cmd.op != CMD_END && raw_idx >= IDX_W'(NUM_STATIONS)) begin
      keep = 1'b0;
    end
    cmd.idx = raw_idx[STN_W-1:0];
  end

  assign in_ready = q_ready;
  assign push     = in_valid && q_ready && keep;

endmodule

`default_nettype wire

// ===== sv/tscc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tscc_queue import tscc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop,
  output cmd_t pop_cmd
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/tscc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tscc_back import tscc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  logic [CNT_W-1:0]  counts [NUM_STATIONS];
  logic [NUM_STATIONS-1:0] hit_map;
  back_state_t       state;
  back_state_t       state_next;
  logic [STN_W-1:0]  scan_idx;
  logic [RUN_W-1:0]  cur_p;
  logic [RUN_W-1:0]  best_p;
  logic [RUN_W-1:0]  cur_h;
  logic [RUN_W-1:0]  best_h;
  logic [RUN_W-1:0]  htot;
  logic [CNT_W-1:0]  pmax;
  logic [MOM_W-1:0]  mom;

  logic [RUN_W-1:0]  cur_p_next;
  logic [RUN_W-1:0]  best_p_next;
  logic [RUN_W-1:0]  cur_h_next;
  logic [RUN_W-1:0]  best_h_next;
  logic [RUN_W-1:0]  htot_next;
  logic [CNT_W-1:0]  pmax_next;

  logic [STN_W-1:0]  rd_idx;
  logic [CNT_W-1:0]  rd_cnt;
  logic              rd_hit;
  logic              pop;
  logic              last;
  logic              step;
  logic              finish;
  logic              cov_ok;
  logic              ok;

  assign rd_idx = (state == BK_SCAN) ? scan_idx : cmd.idx;
  assign rd_cnt = counts[rd_idx];
  assign rd_hit = hit_map[rd_idx];

  assign last   = scan_idx == STN_W'(NUM_STATIONS - 1);
  assign step   = (state == BK_SCAN) && !(last && res_valid && !res_ready);
  assign finish = step && last;

  always_comb begin
    cur_p_next  = (rd_cnt != '0) ? cur_p + 1'b1 : '0;
    best_p_next = (cur_p_next > best_p) ? cur_p_next : best_p;
    cur_h_next  = rd_hit ? cur_h + 1'b1 : '0;
    best_h_next = (cur_h_next > best_h) ? cur_h_next : best_h;
    htot_next   = htot + RUN_W'(rd_hit);
    pmax_next   = (rd_cnt > pmax) ? rd_cnt : pmax;
  end

  always_comb begin
    unique case (cfg.coverage_mode)
      COV_NONE:      cov_ok = 1'b1;
      COV_HIT_RUN:   cov_ok = 32'(best_h_next) >= 32'(cfg.min_station_count);
      COV_HIT_TOTAL: cov_ok = 32'(htot_next) >= 32'(cfg.min_station_count);
      COV_POINT_RUN: cov_ok = 32'(best_p_next) >= 32'(cfg.min_station_count);
      default:       cov_ok = 1'b0;
    endcase
    ok = (mom > cfg.min_momentum) && cov_ok && (pmax_next <= cfg.max_points_per_station);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    unique case (state)
      BK_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid && cmd.op == CMD_END) begin
          state_next = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (finish) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  assign pop = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_STATIONS; i++) begin
        counts[i] <= '0;
      end
      hit_map <= '0;
    end else begin
      if (pop && cmd.op == CMD_POINT && rd_cnt != CNT_MAX) begin
        counts[cmd.idx] <= rd_cnt + 1'b1;
      end
      if (pop && cmd.op == CMD_HIT) begin
        hit_map[cmd.idx] <= 1'b1;
      end
      if (step) begin
        counts[scan_idx]  <= '0;
        hit_map[scan_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && cmd.op == CMD_END) begin
      scan_idx <= '0;
      cur_p    <= '0;
      best_p   <= '0;
      cur_h    <= '0;
      best_h   <= '0;
      htot     <= '0;
      pmax     <= '0;
      mom      <= cmd.mom;
    end else if (step) begin
      scan_idx <= scan_idx + 1'b1;
      cur_p    <= cur_p_next;
      best_p   <= best_p_next;
      cur_h    <= cur_h_next;
      best_h   <= best_h_next;
      htot     <= htot_next;
      pmax     <= pmax_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (finish) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      res.reconstructable        <= ok;
      res.longest_point_run      <= sat_report(best_p_next);
      res.longest_hit_run        <= sat_report(best_h_next);
      res.hit_station_total      <= sat_report(htot_next);
      res.most_points_on_station <= pmax_next;
    end
  end

`ifndef SYNTHESIS
  a_finish_gives_result: assert property (@(posedge clk) disable iff (rst)
    finish |=> res_valid)
    else $error("scan finished without a result");

  a_finish_clears_hits: assert property (@(posedge clk) disable iff (rst)
    finish |=> hit_map == '0)
    else $error("hit map not cleared after track");

  a_end_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (pop && cmd.op == CMD_END) |=> (state == BK_SCAN && scan_idx == '0))
    else $error("end of track did not start scan");
`endif

endmodule

`default_nettype wire

// ===== sv/track_station_coverage_check.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Track station coverage check. Point and hit items of a track are classified
// on entry (outer points matched to their z window, outer items offset by the
// inner station count, out-of-range and unmatched items dropped) and pass
// through a two-entry command queue to the station store, which takes point
// and hit items while idle. An end-of-track item makes the back end walk its
// NUM_STATIONS slots, one per cycle but stalling at the last slot until the
// previous result is taken, building the run, total and maximum figures while
// it clears the store; the result then sits in an output register until taken.
// During the walk the front accepts items until the queue fills. Configuration
// writes are always accepted and are to be made only while the block is idle.
module track_station_coverage_check import tscc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         func,
  input  logic [7:0]         station_number,
  input  logic signed [15:0] z_position,
  input  logic [23:0]        track_momentum,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               reconstructable,
  output logic [4:0]         longest_point_run,
  output logic [4:0]         longest_hit_run,
  output logic [4:0]         hit_station_total,
  output logic [3:0]         most_points_on_station,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  cfg_t cfg;
  logic push;
  logic q_ready;
  cmd_t push_cmd;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;
  res_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inner_station_count    <= 4'd2;
      cfg.min_station_count      <= 5'd4;
      cfg.coverage_mode          <= COV_HIT_RUN;
      cfg.min_momentum           <= '0;
      cfg.max_points_per_station <= 4'd4;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_INNER_STATIONS: cfg.inner_station_count    <= cfg_data[3:0];
        CFG_MIN_STATIONS:   cfg.min_station_count      <= cfg_data[4:0];
        CFG_COVERAGE_MODE:  cfg.coverage_mode          <= cov_mode_t'(cfg_data[1:0]);
        CFG_MIN_MOMENTUM:   cfg.min_momentum           <= cfg_data;
        CFG_MAX_POINTS:     cfg.max_points_per_station <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  tscc_front u_front (
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .func                (func),
    .station_number      (station_number),
    .z_position          (z_position),
    .track_momentum      (track_momentum),
    .inner_station_count (cfg.inner_station_count),
    .q_ready             (q_ready),
    .push                (push),
    .cmd                 (push_cmd)
  );

  tscc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (q_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  tscc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (q_valid),
    .cmd_ready (q_pop),
    .cmd       (q_cmd),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  assign reconstructable        = res.reconstructable;
  assign longest_point_run      = res.longest_point_run;
  assign longest_hit_run        = res.longest_hit_run;
  assign hit_station_total      = res.hit_station_total;
  assign most_points_on_station = res.most_points_on_station;

endmodule

`default_nettype wire
